### rtl/pse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

	localparam int unsigned PCW_DEFAULT = 16;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SPEED_W = 24;
	localparam int unsigned FILT_W  = 32;
	localparam int unsigned MUL_A_W = 32;
	localparam int unsigned MUL_B_W = 24;
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned REG_IDX_W = 3;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_EDGE  = 2'd0;
	localparam logic [OP_W-1:0] OP_POLL  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

	// Register indexes (byte address is four times the index).
	localparam logic [REG_IDX_W-1:0] REG_SENSOR_EN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_INTERVAL  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SCALE     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LOCKOUT   = 3'd6;

	// Register reset values.
	localparam logic        RST_SENSOR_EN = 1'b1;
	localparam logic [15:0] RST_INTERVAL  = 16'd50;
	localparam logic [15:0] RST_MIN_PULSE = 16'd1;
	localparam logic [16:0] RST_ALPHA     = 17'd19661;
	localparam logic [23:0] RST_SCALE     = 24'd40960;
	localparam logic [23:0] RST_THRESHOLD = 24'd256;
	localparam logic [15:0] RST_LOCKOUT   = 16'd1000;

	// Q0.16 smoothing weights 0.7 and 0.3, and 1.0 as a Q1.16 constant.
	localparam logic [15:0] W_NEW   = 16'd45875;
	localparam logic [15:0] W_OLD   = 16'd19661;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Multiplier operand selections.
	localparam logic [2:0] MUL_ZERO        = 3'd0;
	localparam logic [2:0] MUL_RAW_ALPHA   = 3'd1;
	localparam logic [2:0] MUL_FILT_INVA   = 3'd2;
	localparam logic [2:0] MUL_FILT_SCALE  = 3'd3;
	localparam logic [2:0] MUL_WNEW_NOW    = 3'd4;
	localparam logic [2:0] MUL_WNEW_SMOOTH = 3'd5;
	localparam logic [2:0] MUL_WOLD_SMOOTH = 3'd6;

	typedef struct packed {
		logic        sensor_enabled;
		logic [15:0] interval_ms;
		logic [15:0] min_pulses;
		logic [16:0] ema_alpha;
		logic [23:0] speed_scale;
		logic [23:0] stable_threshold;
		logic [15:0] lockout_us;
	} cfg_t;

	typedef struct packed {
		logic       accept;
		logic [2:0] mul_sel;
		logic       acc_load;
		logic       filt_ema;
		logic       speed_calc;
		logic       smooth_calc;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic calc;
		logic long_count;
	} dp_status_t;

endpackage
`default_nettype wire

### rtl/pse_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pse_in_if import pse_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [TIME_W-1:0]   time_us;
	logic [TIME_W-1:0]   time_ms;

	modport source(output valid, operation, time_us, time_ms, input ready);
	modport sink(input valid, operation, time_us, time_ms, output ready);
endinterface

interface pse_out_if import pse_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] current_speed;
	logic [SPEED_W-1:0] smoothed_speed;
	logic               stable;
	logic               sample_taken;
	logic               edge_counted;

	modport source(output valid, current_speed, smoothed_speed, stable, sample_taken,
		edge_counted, input ready);
	modport sink(input valid, current_speed, smoothed_speed, stable, sample_taken,
		edge_counted, output ready);
endinterface
`default_nettype wire

### rtl/pse_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module pse_regs import pse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;
	cfg_t                 cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_enabled   <= RST_SENSOR_EN;
			cfg_q.interval_ms      <= RST_INTERVAL;
			cfg_q.min_pulses       <= RST_MIN_PULSE;
			cfg_q.ema_alpha        <= RST_ALPHA;
			cfg_q.speed_scale      <= RST_SCALE;
			cfg_q.stable_threshold <= RST_THRESHOLD;
			cfg_q.lockout_us       <= RST_LOCKOUT;
		end else if (wr_en) begin
			case (idx)
				REG_SENSOR_EN: cfg_q.sensor_enabled   <= pwdata[0];
				REG_INTERVAL:  cfg_q.interval_ms      <= pwdata[15:0];
				REG_MIN_PULSE: cfg_q.min_pulses       <= pwdata[15:0];
				REG_ALPHA:     cfg_q.ema_alpha        <= pwdata[16:0];
				REG_SCALE:     cfg_q.speed_scale      <= pwdata[23:0];
				REG_THRESHOLD: cfg_q.stable_threshold <= pwdata[23:0];
				REG_LOCKOUT:   cfg_q.lockout_us       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SENSOR_EN: prdata = PDATA_W'(cfg_q.sensor_enabled);
			REG_INTERVAL:  prdata = PDATA_W'(cfg_q.interval_ms);
			REG_MIN_PULSE: prdata = PDATA_W'(cfg_q.min_pulses);
			REG_ALPHA:     prdata = PDATA_W'(cfg_q.ema_alpha);
			REG_SCALE:     prdata = PDATA_W'(cfg_q.speed_scale);
			REG_THRESHOLD: prdata = PDATA_W'(cfg_q.stable_threshold);
			REG_LOCKOUT:   prdata = PDATA_W'(cfg_q.lockout_us);
			default:       prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

### rtl/pse_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module pse_dp import pse_pkg::*; #(
	parameter int unsigned PULSE_COUNT_WIDTH = PCW_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic [OP_W-1:0]    operation,
	input  logic [TIME_W-1:0]  time_us,
	input  logic [TIME_W-1:0]  time_ms,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	output logic [SPEED_W-1:0] current_speed,
	output logic [SPEED_W-1:0] smoothed_speed,
	output logic               stable,
	output logic               sample_taken,
	output logic               edge_counted
);
	localparam logic [PULSE_COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Architectural state.
	logic [PULSE_COUNT_WIDTH-1:0] count_q;
	logic [TIME_W-1:0]  last_edge_q;
	logic [TIME_W-1:0]  last_calc_q;
	logic [FILT_W-1:0]  filt_q;
	logic [SPEED_W-1:0] speed_now_q;
	logic [SPEED_W-1:0] smooth_q;
	logic [SPEED_W-1:0] prev_q;
	logic               stable_f_q;
	logic               sample_f_q;
	logic               edge_f_q;

	// Working registers of the calculation.
	logic [FILT_W-1:0]  raw_q;
	logic [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]  acc_q;

	logic [FILT_W-1:0]  count_ext;
	logic [TIME_W-1:0]  edge_delta;
	logic [TIME_W-1:0]  poll_delta;
	logic               edge_ok;
	logic               poll_due;
	logic [SPEED_W-1:0] speed_diff;
	logic [16:0]        alpha_clamp;
	logic [16:0]        alpha_inv;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W:0]    t2_round;
	logic [PROD_W:0]    ema_sum;
	logic [FILT_W-1:0]  filt_next;
	logic [PROD_W:0]    spd_round;
	logic [SPEED_W-1:0] speed_next;
	logic [PROD_W:0]    smooth_sum;

	assign count_ext  = FILT_W'(count_q);
	assign edge_delta = time_us - last_edge_q;
	assign poll_delta = time_ms - last_calc_q;
	assign edge_ok    = edge_delta > TIME_W'(cfg.lockout_us);
	assign poll_due   = poll_delta >= TIME_W'(cfg.interval_ms);
	assign speed_diff = (speed_now_q >= prev_q) ? speed_now_q - prev_q : prev_q - speed_now_q;

	assign status.calc       = (operation == OP_POLL) && cfg.sensor_enabled && poll_due;
	assign status.long_count = count_ext >= FILT_W'(cfg.min_pulses);

	// Alpha above 1.0 acts as 1.0.
	assign alpha_clamp = (cfg.ema_alpha > ONE_Q16) ? ONE_Q16 : cfg.ema_alpha;
	assign alpha_inv   = ONE_Q16 - alpha_clamp;

	always_comb begin
		case (cmd.mul_sel)
			MUL_RAW_ALPHA: begin
				mul_a = raw_q;
				mul_b = MUL_B_W'(alpha_clamp);
			end
			MUL_FILT_INVA: begin
				mul_a = filt_q;
				mul_b = MUL_B_W'(alpha_inv);
			end
			MUL_FILT_SCALE: begin
				mul_a = filt_q;
				mul_b = cfg.speed_scale;
			end
			MUL_WNEW_NOW: begin
				mul_a = MUL_A_W'(W_NEW);
				mul_b = speed_now_q;
			end
			MUL_WNEW_SMOOTH: begin
				mul_a = MUL_A_W'(W_NEW);
				mul_b = smooth_q;
			end
			MUL_WOLD_SMOOTH: begin
				mul_a = MUL_A_W'(W_OLD);
				mul_b = smooth_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// EMA: alpha*count + round((1-alpha)*filtered), saturated to 32 bits.
	assign t2_round  = ((PROD_W+1)'(prod_q) + (PROD_W+1)'(32768)) >> 16;
	assign ema_sum   = (PROD_W+1)'(acc_q) + t2_round;
	assign filt_next = (|ema_sum[PROD_W:FILT_W]) ? '1 : ema_sum[FILT_W-1:0];

	// Q16.16 times Q12.12 gives Q28.28; round to Q16.8 and saturate.
	assign spd_round  = ((PROD_W+1)'(prod_q) + (PROD_W+1)'(524288)) >> 20;
	assign speed_next = (|spd_round[PROD_W:SPEED_W]) ? '1 : spd_round[SPEED_W-1:0];

	// The two weights sum to 1.0, so the rounded sum always fits 24 bits.
	assign smooth_sum = (PROD_W+1)'(acc_q) + (PROD_W+1)'(prod_q) + (PROD_W+1)'(32768);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end
		if (cmd.accept && status.calc) begin
			raw_q <= count_ext;
		end
		if (cmd.out_load) begin
			current_speed  <= speed_now_q;
			smoothed_speed <= smooth_q;
			stable         <= stable_f_q;
			sample_taken   <= sample_f_q;
			edge_counted   <= edge_f_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_edge_q <= '0;
			last_calc_q <= '0;
			filt_q      <= '0;
			speed_now_q <= '0;
			smooth_q    <= '0;
			prev_q      <= '0;
			stable_f_q  <= 1'b0;
			sample_f_q  <= 1'b0;
			edge_f_q    <= 1'b0;
		end else begin
			if (cmd.accept) begin
				stable_f_q <= 1'b0;
				sample_f_q <= 1'b0;
				edge_f_q   <= 1'b0;
				case (operation)
					OP_EDGE: begin
						if (edge_ok) begin
							if (count_q != COUNT_MAX) begin
								count_q <= count_q + 1'b1;
							end
							last_edge_q <= time_us;
							edge_f_q    <= 1'b1;
						end
					end
					OP_POLL: begin
						if (!cfg.sensor_enabled) begin
							speed_now_q <= '0;
							smooth_q    <= '0;
						end else if (poll_due) begin
							count_q     <= '0;
							last_calc_q <= time_ms;
							sample_f_q  <= 1'b1;
							if (!status.long_count) begin
								filt_q <= filt_q >> 1;
							end
						end
					end
					OP_QUERY: begin
						stable_f_q <= speed_diff < cfg.stable_threshold;
						prev_q     <= speed_now_q;
					end
					default: begin
						speed_now_q <= '0;
						smooth_q    <= '0;
					end
				endcase
			end
			if (cmd.filt_ema) begin
				filt_q <= filt_next;
			end
			if (cmd.speed_calc) begin
				speed_now_q <= speed_next;
			end
			if (cmd.smooth_calc) begin
				smooth_q <= smooth_sum[SPEED_W+15:16];
			end
		end
	end
endmodule
`default_nettype wire

### rtl/pse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pse_ctrl import pse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_V1   = 4'd1;
	localparam logic [3:0] S_V2   = 4'd2;
	localparam logic [3:0] S_V3   = 4'd3;
	localparam logic [3:0] S_C1   = 4'd4;
	localparam logic [3:0] S_C2   = 4'd5;
	localparam logic [3:0] S_W1   = 4'd6;
	localparam logic [3:0] S_W2   = 4'd7;
	localparam logic [3:0] S_W3   = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       short_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_ZERO;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					if (!status.calc) begin
						state_d = S_DONE;
					end else if (status.long_count) begin
						state_d = S_V1;
					end else begin
						state_d = S_C1;
					end
				end
			end
			S_V1: begin
				cmd.mul_sel = MUL_RAW_ALPHA;
				state_d     = S_V2;
			end
			S_V2: begin
				cmd.acc_load = 1'b1;
				cmd.mul_sel  = MUL_FILT_INVA;
				state_d      = S_V3;
			end
			S_V3: begin
				cmd.filt_ema = 1'b1;
				state_d      = S_C1;
			end
			S_C1: begin
				cmd.mul_sel = MUL_FILT_SCALE;
				state_d     = S_C2;
			end
			S_C2: begin
				cmd.speed_calc = 1'b1;
				state_d        = S_W1;
			end
			S_W1: begin
				// A short count only decays the smoothed speed by 0.7.
				cmd.mul_sel = short_q ? MUL_WNEW_SMOOTH : MUL_WNEW_NOW;
				state_d     = S_W2;
			end
			S_W2: begin
				cmd.acc_load = 1'b1;
				cmd.mul_sel  = short_q ? MUL_ZERO : MUL_WOLD_SMOOTH;
				state_d      = S_W3;
			end
			S_W3: begin
				cmd.smooth_calc = 1'b1;
				state_d         = S_DONE;
			end
			S_DONE: begin
				cmd.out_load = !out_valid_q || out_ready;
				if (cmd.out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			short_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				short_q <= !status.long_count;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/pulse_speed_estimator.sv
// Edge, stability query, stop and a poll that does no calculation go straight from idle to
// the done state. A calculating poll first runs a sequence on one shared 32x24 multiplier: EMA
// states V1 to V3 for a count at or above the minimum (a short count skips them), speed states
// C1 and C2 and smoothing states W1 to W3. Done loads the output register once it is free;
// an input transaction is then taken while the finished result waits. Asynchronous active-low reset
// loads the register reset values and clears all state but the working and output data registers.
`timescale 1ns / 1ps
`default_nettype none
module pulse_speed_estimator import pse_pkg::*; #(
	parameter int unsigned PULSE_COUNT_WIDTH = PCW_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	pse_in_if.sink             item,
	pse_out_if.source          result
);
	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	pse_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	pse_dp #(
		.PULSE_COUNT_WIDTH (PULSE_COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.operation      (item.operation),
		.time_us        (item.time_us),
		.time_ms        (item.time_ms),
		.cmd            (cmd),
		.status         (status),
		.current_speed  (result.current_speed),
		.smoothed_speed (result.smoothed_speed),
		.stable         (result.stable),
		.sample_taken   (result.sample_taken),
		.edge_counted   (result.edge_counted)
	);

	// Once an item is taken the block is busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("input taken on two consecutive cycles");

	// A result flags at most one kind of event.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.sample_taken && result.edge_counted)
			&& !(result.stable && (result.sample_taken || result.edge_counted)))
		else $error("result flags more than one event");

	// The accept, filter, speed, smooth and output-load commands only issue one at a time.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.filt_ema, cmd.speed_calc, cmd.smooth_calc, cmd.out_load}))
		else $error("overlapping datapath commands");

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import pse_pkg::*;

	localparam int unsigned CLK_HALF       = 4;
	localparam int unsigned RESET_CYCLES   = 9;
	localparam int unsigned NUM_PHASES     = 6;
	localparam int unsigned ITEMS_PER_PHASE = 275;
	localparam int unsigned SETTLE_CYCLES  = 16;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned LONG_HOLD      = 400;
	localparam int unsigned MAX_REPORTS    = 10;
	// A narrow pulse counter lets the run reach saturation.
	localparam int unsigned PULSE_W        = 8;

	typedef struct packed {
		logic [SPEED_W-1:0] current_speed;
		logic [SPEED_W-1:0] smoothed_speed;
		logic               stable;
		logic               sample_taken;
		logic               edge_counted;
	} speed_out_t;

	typedef struct {
		bit                    is_reg;
		logic [REG_IDX_W-1:0]  reg_idx;
		logic [PDATA_W-1:0]    value;
		logic [OP_W-1:0]       op;
		logic [TIME_W-1:0]     t_us;
		logic [TIME_W-1:0]     t_ms;
		bit                    typed;
		speed_out_t            want;
	} stim_row_t;

	localparam speed_out_t NO_CHANGE    = '0;
	localparam speed_out_t EDGE_TAKEN   = {24'd0, 24'd0, 1'b0, 1'b0, 1'b1};
	localparam speed_out_t STILL_STABLE = {24'd0, 24'd0, 1'b1, 1'b0, 1'b0};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	pse_in_if  in_ch();
	pse_out_if out_ch();

	pulse_speed_estimator #(
		.PULSE_COUNT_WIDTH (PULSE_W)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (in_ch),
		.result  (out_ch)
	);

	// Mirror of the block's registers and state.
	cfg_t                   cfg_m;
	logic [PULSE_W-1:0]     pulses;
	logic [FILT_W-1:0]      filt_pulses;
	logic [TIME_W-1:0]      last_edge;
	logic [TIME_W-1:0]      last_calc;
	logic [SPEED_W-1:0]     spd_now;
	logic [SPEED_W-1:0]     spd_smooth;
	logic [SPEED_W-1:0]     spd_at_query;

	speed_out_t  pending_speeds[$];
	stim_row_t   stim_table[$];
	int unsigned mismatches;
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned rx_hold_cycles;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [SPEED_W-1:0] scale_speed(input logic [FILT_W-1:0] filt);
		logic [63:0] prod;
		logic [63:0] rounded;
		prod = 64'(filt) * 64'(cfg_m.speed_scale);
		rounded = (prod + 64'(1 << 19)) >> 20;
		return (rounded > 64'hFF_FFFF) ? 24'hFF_FFFF : rounded[SPEED_W-1:0];
	endfunction

	// Advances the mirrored state by one transaction and returns the speeds it should report.
	function automatic speed_out_t estimate_speed(input logic [OP_W-1:0] op,
		input logic [TIME_W-1:0] t_us, input logic [TIME_W-1:0] t_ms);
		speed_out_t             r;
		logic [TIME_W-1:0]      dt;
		logic [PULSE_W-1:0]     raw;
		logic [63:0]            alpha;
		logic [63:0]            mix;
		logic [63:0]            old_part;
		logic [63:0]            smooth_acc;
		logic [SPEED_W-1:0]     diff;
		r = '0;
		case (op)
			OP_EDGE: begin
				dt = t_us - last_edge;
				if (dt > 32'(cfg_m.lockout_us)) begin
					if (pulses != '1)
						pulses = pulses + 1'b1;
					last_edge = t_us;
					r.edge_counted = 1'b1;
				end
			end
			OP_POLL: begin
				dt = t_ms - last_calc;
				if (!cfg_m.sensor_enabled) begin
					spd_now = '0;
					spd_smooth = '0;
				end else if (dt >= 32'(cfg_m.interval_ms)) begin
					raw = pulses;
					pulses = '0;
					if (32'(raw) >= 32'(cfg_m.min_pulses)) begin
						alpha = (cfg_m.ema_alpha > ONE_Q16) ? 64'(ONE_Q16) : 64'(cfg_m.ema_alpha);
						old_part = (64'(ONE_Q16) - alpha) * 64'(filt_pulses);
						mix = alpha * 64'(raw) + ((old_part + 64'd32768) >> 16);
						filt_pulses = (mix > 64'hFFFF_FFFF) ? '1 : mix[FILT_W-1:0];
						spd_now = scale_speed(filt_pulses);
						smooth_acc = 64'(W_NEW) * 64'(spd_now) + 64'(W_OLD) * 64'(spd_smooth)
							+ 64'd32768;
					end else begin
						filt_pulses = filt_pulses >> 1;
						spd_now = scale_speed(filt_pulses);
						smooth_acc = 64'(W_NEW) * 64'(spd_smooth) + 64'd32768;
					end
					spd_smooth = smooth_acc[16 +: SPEED_W];
					last_calc = t_ms;
					r.sample_taken = 1'b1;
				end
			end
			OP_QUERY: begin
				diff = (spd_now >= spd_at_query) ? spd_now - spd_at_query : spd_at_query - spd_now;
				spd_at_query = spd_now;
				r.stable = (diff < cfg_m.stable_threshold);
			end
			default: begin
				spd_now = '0;
				spd_smooth = '0;
			end
		endcase
		r.current_speed = spd_now;
		r.smoothed_speed = spd_smooth;
		return r;
	endfunction

	function automatic void add_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		stim_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.value = value;
		stim_table.push_back(row);
	endfunction

	function automatic void add_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t_us,
		input logic [TIME_W-1:0] t_ms, input bit typed, input speed_out_t want);
		stim_row_t row;
		row = '{default: '0};
		row.op = op;
		row.t_us = t_us;
		row.t_ms = t_ms;
		row.typed = typed;
		row.want = want;
		stim_table.push_back(row);
	endfunction

	function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
		input int unsigned mid_hi);
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return lo;
		if (sel == 1)
			return hi;
		return $urandom_range(lo, mid_hi);
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_SENSOR_EN: cfg_m.sensor_enabled = value[0];
			REG_INTERVAL:  cfg_m.interval_ms = value[15:0];
			REG_MIN_PULSE: cfg_m.min_pulses = value[15:0];
			REG_ALPHA:     cfg_m.ema_alpha = value[16:0];
			REG_SCALE:     cfg_m.speed_scale = value[23:0];
			REG_THRESHOLD: cfg_m.stable_threshold = value[23:0];
			REG_LOCKOUT:   cfg_m.lockout_us = value[15:0];
			default: ;
		endcase
	endtask

	task automatic end_reg_writes();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_results_done();
		in_ch.valid <= 1'b0;
		while (pending_speeds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t_us,
		input logic [TIME_W-1:0] t_ms, input bit typed, input speed_out_t want);
		speed_out_t  model_out;
		int unsigned gap;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.time_us <= t_us;
		in_ch.time_ms <= t_ms;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		model_out = estimate_speed(op, t_us, t_ms);
		pending_speeds.push_back(typed ? want : model_out);
	endtask

	// The receiver's ready; a requested hold-off is counted down here.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles = rx_hold_cycles - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		speed_out_t got;
		speed_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.current_speed, out_ch.smoothed_speed, out_ch.stable,
				out_ch.sample_taken, out_ch.edge_counted};
			if (pending_speeds.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result transaction with nothing expected", $time);
			end else begin
				want = pending_speeds.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: mismatch: expected speed %h smooth %h stable %b ",
							"sample %b edge %b, got speed %h smooth %h stable %b sample %b edge %b"},
							$time, want.current_speed, want.smoothed_speed, want.stable,
							want.sample_taken, want.edge_counted, got.current_speed,
							got.smoothed_speed, got.stable, got.sample_taken, got.edge_counted);
				end
			end
		end
	end

	// Ends the run when no transaction moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("pulse_speed_estimator test failed");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t         row;
		logic [OP_W-1:0]   op;
		logic [TIME_W-1:0] t_us;
		logic [TIME_W-1:0] t_ms;
		logic [TIME_W-1:0] us_clk;
		logic [TIME_W-1:0] ms_clk;
		int unsigned       kind;
		int unsigned       lk;
		int unsigned       iv;
		int unsigned       alpha_sel;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_EDGE;
		in_ch.time_us = '0;
		in_ch.time_ms = '0;
		mismatches = 0;
		idle_cycles = 0;
		rx_hold_cycles = 0;
		tx_idle_pct = 25;
		rx_stall_pct = 66;

		cfg_m = {RST_SENSOR_EN, RST_INTERVAL, RST_MIN_PULSE, RST_ALPHA, RST_SCALE,
			RST_THRESHOLD, RST_LOCKOUT};
		pulses = '0;
		filt_pulses = '0;
		last_edge = '0;
		last_calc = '0;
		spd_now = '0;
		spd_smooth = '0;
		spd_at_query = '0;

		// Directed part: lockout edges, wrapped timestamps, polls around the interval,
		// disabled sensor, zero interval, alpha above one and the register extremes.
		add_item(OP_QUERY, '0, '0, 1'b1, STILL_STABLE);
		add_item(OP_EDGE, 32'd0, '1, 1'b1, NO_CHANGE);
		add_item(OP_EDGE, 32'd1000, '0, 1'b1, NO_CHANGE);
		add_item(OP_EDGE, 32'd1001, '1, 1'b1, EDGE_TAKEN);
		add_item(OP_EDGE, 32'hFFFF_FFFF, '0, 1'b1, EDGE_TAKEN);
		add_item(OP_EDGE, 32'd500, '1, 1'b1, NO_CHANGE);
		add_item(OP_POLL, '1, 32'd49, 1'b1, NO_CHANGE);
		add_item(OP_POLL, '0, 32'd50, 1'b0, NO_CHANGE);
		add_item(OP_POLL, '1, 32'hFFFF_FFFF, 1'b0, NO_CHANGE);
		add_item(OP_QUERY, '1, '1, 1'b0, NO_CHANGE);
		add_item(OP_STOP, '1, '1, 1'b1, NO_CHANGE);
		add_item(OP_QUERY, '0, '0, 1'b0, NO_CHANGE);
		add_reg(REG_SENSOR_EN, 32'd0);
		add_item(OP_EDGE, 32'h8000_0000, '0, 1'b0, NO_CHANGE);
		add_item(OP_POLL, '0, 32'd0, 1'b1, NO_CHANGE);
		add_reg(REG_SENSOR_EN, 32'd1);
		add_reg(REG_INTERVAL, 32'd0);
		add_reg(REG_LOCKOUT, 32'd0);
		add_item(OP_POLL, '0, 32'hFFFF_FFFF, 1'b0, NO_CHANGE);
		add_item(OP_EDGE, 32'h8000_0000, '0, 1'b0, NO_CHANGE);
		add_item(OP_EDGE, 32'h8000_0001, '0, 1'b0, NO_CHANGE);
		add_reg(REG_ALPHA, 32'h1_FFFF);
		add_reg(REG_SCALE, 32'hFF_FFFF);
		add_reg(REG_MIN_PULSE, 32'd0);
		add_item(OP_POLL, '0, 32'd0, 1'b0, NO_CHANGE);
		add_reg(REG_THRESHOLD, 32'd0);
		add_item(OP_QUERY, '0, '0, 1'b0, NO_CHANGE);
		add_reg(REG_THRESHOLD, 32'hFF_FFFF);
		add_reg(REG_LOCKOUT, 32'hFFFF);
		add_reg(REG_INTERVAL, 32'hFFFF);
		add_reg(REG_MIN_PULSE, 32'hFFFF);
		add_item(OP_QUERY, '0, '0, 1'b0, NO_CHANGE);
		add_item(OP_EDGE, 32'h8001_0001, '0, 1'b0, NO_CHANGE);
		add_item(OP_EDGE, 32'h8002_0000, '0, 1'b0, NO_CHANGE);
		add_item(OP_POLL, '0, 32'h0000_FFFE, 1'b0, NO_CHANGE);
		add_item(OP_POLL, '0, 32'h0000_FFFF, 1'b0, NO_CHANGE);
		add_reg(REG_ALPHA, 32'd0);
		add_item(OP_STOP, '0, '0, 1'b0, NO_CHANGE);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			row = stim_table[i];
			if (row.is_reg) begin
				wait_results_done();
				write_reg(row.reg_idx, row.value);
				end_reg_writes();
			end else begin
				send_item(row.op, row.t_us, row.t_ms, row.typed, row.want);
			end
		end

		// Random part: most transactions follow advancing timestamps so that edges often pass the
		// lockout and polls often fall due; about one in ten carries random timestamps.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_results_done();
			if (phase < 2) begin
				tx_idle_pct = 25;
				rx_stall_pct = 66;
			end else if (phase < 4) begin
				tx_idle_pct = 66;
				rx_stall_pct = 25;
			end else begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			alpha_sel = $urandom_range(0, 7);
			write_reg(REG_SENSOR_EN, 32'($urandom_range(0, 7) != 0));
			write_reg(REG_INTERVAL, pick_value(1, 32'hFFFF, 200));
			write_reg(REG_MIN_PULSE, pick_value(0, 32'hFFFF, 4));
			write_reg(REG_ALPHA, (alpha_sel == 0) ? 32'd0 : (alpha_sel == 1) ? 32'h1_0000 :
				(alpha_sel == 2) ? 32'h1_FFFF : $urandom_range(0, 32'h1_0000));
			write_reg(REG_SCALE, pick_value(0, 32'hFF_FFFF, 32'hFF_FFFF));
			write_reg(REG_THRESHOLD, pick_value(0, 32'hFF_FFFF, 4096));
			write_reg(REG_LOCKOUT, pick_value(0, 32'hFFFF, 2000));
			end_reg_writes();
			us_clk = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 300000);
			ms_clk = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 2000);
			lk = cfg_m.lockout_us;
			iv = cfg_m.interval_ms;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// A long receiver hold-off fills the block while the sender keeps offering.
				if (phase == 1 && n == 100)
					rx_hold_cycles = LONG_HOLD;
				if (phase == 3 && n == 150)
					wait_results_done();
				kind = $urandom_range(0, 99);
				op = (kind < 55) ? OP_EDGE : (kind < 80) ? OP_POLL : (kind < 92) ? OP_QUERY : OP_STOP;
				t_us = $urandom;
				t_ms = $urandom;
				if ($urandom_range(0, 9) != 0) begin
					if (op == OP_EDGE) begin
						us_clk = us_clk + $urandom_range(0, 2 * lk + 2);
						t_us = us_clk;
					end else if (op == OP_POLL) begin
						ms_clk = ms_clk + $urandom_range(iv / 2, iv + iv / 2 + 1);
						t_ms = ms_clk;
					end
				end
				send_item(op, t_us, t_ms, 1'b0, NO_CHANGE);
			end
		end

		// Saturate the pulse counter, then poll with the largest scale so the current speed clips.
		wait_results_done();
		write_reg(REG_SENSOR_EN, 32'd1);
		write_reg(REG_INTERVAL, 32'd0);
		write_reg(REG_MIN_PULSE, 32'((1 << PULSE_W) - 1));
		write_reg(REG_ALPHA, 32'h1_0000);
		write_reg(REG_SCALE, 32'hFF_FFFF);
		write_reg(REG_THRESHOLD, 32'd0);
		write_reg(REG_LOCKOUT, 32'd0);
		end_reg_writes();
		us_clk = $urandom;
		for (int k = 0; k < (1 << PULSE_W) + 1; k++) begin
			us_clk = us_clk + 1;
			send_item(OP_EDGE, us_clk, $urandom, 1'b0, NO_CHANGE);
		end
		send_item(OP_POLL, $urandom, $urandom, 1'b0, NO_CHANGE);
		send_item(OP_QUERY, $urandom, $urandom, 1'b0, NO_CHANGE);
		send_item(OP_POLL, $urandom, $urandom, 1'b0, NO_CHANGE);
		send_item(OP_QUERY, $urandom, $urandom, 1'b0, NO_CHANGE);
		send_item(OP_STOP, $urandom, $urandom, 1'b0, NO_CHANGE);

		wait_results_done();
		if (mismatches == 0 && pending_speeds.size() == 0) begin
			$display("pulse_speed_estimator test passed");
		end else begin
			$display("pulse_speed_estimator test failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/pse_pkg.sv
rtl/pse_if.sv
rtl/pse_regs.sv
rtl/pse_dp.sv
rtl/pse_ctrl.sv
rtl/pulse_speed_estimator.sv
dv/tb_top.sv
